// ===== rtl/frc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly control package
// Shared types, register indexes, mode and action codes and drop cause bits.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int PAYLOAD_BYTES = 1024;

    localparam int SEQ_W   = 16;
    localparam int ID_W    = 32;
    localparam int FIDX_W  = 16;
    localparam int PLEN_W  = 16;
    localparam int BYTES_W = 24;
    localparam int APP_W   = 11;

    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 3;

    // register indexes
    localparam logic [1:0] REG_KEY_AFTER_LOSS = 2'd0;
    localparam logic [1:0] REG_MAX_FRAME      = 2'd1;

    // mode codes
    localparam logic [1:0] MODE_SEEK = 2'd0;
    localparam logic [1:0] MODE_IN   = 2'd1;
    localparam logic [1:0] MODE_DROP = 2'd2;

    // action codes
    localparam logic [1:0] ACT_DISCARD = 2'd0;
    localparam logic [1:0] ACT_APPEND  = 2'd1;
    localparam logic [1:0] ACT_DONE    = 2'd2;

    // drop cause bits
    localparam int CAUSE_SEQ_GAP  = 0;
    localparam int CAUSE_NO_END   = 1;
    localparam int CAUSE_FRAG_ERR = 2;
    localparam int CAUSE_OVERFLOW = 3;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq_num;
        logic [ID_W-1:0]   frame_ident;
        logic [FIDX_W-1:0] frag_num;
        logic [PLEN_W-1:0] pay_bytes;
        logic              is_padding;
        logic              is_start;
        logic              is_end;
        logic              key_flag;
    } t_item;

    typedef struct packed {
        logic [1:0]         action;
        logic [APP_W-1:0]   append_bytes;
        logic               seq_gap;
        logic [3:0]         drop_causes;
        logic [ID_W-1:0]    done_frame_id;
        logic               done_keyframe;
        logic [BYTES_W-1:0] done_length;
        logic               was_padding;
    } t_result;

    typedef struct packed {
        logic               keyframe_after_loss;
        logic [BYTES_W-1:0] max_frame_size;
    } t_cfg;

endpackage

// ===== rtl/frc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly decision core
// Holds the reassembly state and decides one header per enabled cycle.
// ----------------------------------------------------------------------------
module frc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  frc_pkg::t_item  i_item,
    input  frc_pkg::t_cfg   i_cfg,
    output frc_pkg::t_result o_res
);
    import frc_pkg::*;

    logic [1:0]         r_mode, n_mode;
    logic               r_seq_known, n_seq_known;
    logic [SEQ_W-1:0]   r_next_seq, n_next_seq;
    logic [ID_W-1:0]    r_cur_id, n_cur_id;
    logic               r_cur_key, n_cur_key;
    logic [FIDX_W-1:0]  r_next_frag, n_next_frag;
    logic [BYTES_W-1:0] r_frame_bytes, n_frame_bytes;

    logic [PLEN_W-1:0]  len;
    logic [BYTES_W:0]   sum;
    logic               go;
    logic               gap;

    always_comb begin
        n_mode        = (r_mode == MODE_IN || r_mode == MODE_DROP) ? r_mode : MODE_SEEK;
        n_seq_known   = r_seq_known;
        n_next_seq    = r_next_seq;
        n_cur_id      = r_cur_id;
        n_cur_key     = r_cur_key;
        n_next_frag   = r_next_frag;
        n_frame_bytes = r_frame_bytes;
        o_res         = '0;
        go            = 1'b0;
        gap           = 1'b0;
        sum           = '0;
        len = (i_item.pay_bytes > PLEN_W'(PAYLOAD_BYTES)) ?
              PLEN_W'(PAYLOAD_BYTES) : i_item.pay_bytes;

        n_next_seq  = i_item.seq_num + SEQ_W'(1);
        n_seq_known = 1'b1;

        if (i_item.is_padding) begin
            o_res.was_padding = 1'b1;
        end else begin
            gap = r_seq_known && (i_item.seq_num != r_next_seq);
            if (gap) begin
                o_res.seq_gap = 1'b1;
                if (n_mode == MODE_IN) begin
                    n_frame_bytes = '0;
                    n_next_frag   = '0;
                    o_res.drop_causes[CAUSE_SEQ_GAP] = 1'b1;
                end
                n_mode = MODE_DROP;
            end

            case (n_mode)
                MODE_DROP: begin
                    if (i_item.is_start &&
                        !(i_cfg.keyframe_after_loss && !i_item.key_flag)) begin
                        go = 1'b1;
                        n_mode = MODE_IN;
                    end
                end
                MODE_IN: begin
                    go = 1'b1;
                    if (i_item.is_start && i_item.frame_ident != r_cur_id) begin
                        o_res.drop_causes[CAUSE_NO_END] = 1'b1;
                    end
                end
                default: begin
                    if (i_item.is_start) begin
                        go = 1'b1;
                        n_mode = MODE_IN;
                    end
                end
            endcase

            // begin a new frame: from seek or drop on any accepted start, in
            // frame only when the id changes or after a sequence gap
            if (go && i_item.is_start &&
                (r_mode != MODE_IN || gap || i_item.frame_ident != r_cur_id)) begin
                n_cur_id      = i_item.frame_ident;
                n_cur_key     = i_item.key_flag;
                n_next_frag   = i_item.frag_num;
                n_frame_bytes = '0;
            end

            if (go) begin
                sum = {1'b0, n_frame_bytes} + (BYTES_W+1)'(len);
                if (i_item.frag_num != n_next_frag) begin
                    n_frame_bytes = '0;
                    n_next_frag   = '0;
                    o_res.drop_causes[CAUSE_FRAG_ERR] = 1'b1;
                    n_mode = MODE_DROP;
                end else if (sum > {1'b0, i_cfg.max_frame_size}) begin
                    n_frame_bytes = '0;
                    n_next_frag   = '0;
                    o_res.drop_causes[CAUSE_OVERFLOW] = 1'b1;
                    n_mode = MODE_DROP;
                end else begin
                    n_frame_bytes      = sum[BYTES_W-1:0];
                    n_next_frag        = n_next_frag + FIDX_W'(1);
                    o_res.append_bytes = len[APP_W-1:0];
                    o_res.action       = ACT_APPEND;
                    if (i_item.is_end) begin
                        o_res.action        = ACT_DONE;
                        o_res.done_frame_id = n_cur_id;
                        o_res.done_keyframe = n_cur_key;
                        o_res.done_length   = sum[BYTES_W-1:0];
                        n_frame_bytes       = '0;
                        n_mode              = MODE_SEEK;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_SEEK;
            r_seq_known   <= 1'b0;
            r_next_seq    <= '0;
            r_cur_id      <= '0;
            r_cur_key     <= 1'b0;
            r_next_frag   <= '0;
            r_frame_bytes <= '0;
        end else if (i_en) begin
            r_mode        <= n_mode;
            r_seq_known   <= n_seq_known;
            r_next_seq    <= n_next_seq;
            r_cur_id      <= n_cur_id;
            r_cur_key     <= n_cur_key;
            r_next_frag   <= n_next_frag;
            r_frame_bytes <= n_frame_bytes;
        end
    end

endmodule

// ===== rtl/fragment_reassembly_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly control
// A header passes through the input register, then the result register.
// Throughput: one header per cycle while the result stream is not stalled, set by
// the single state update in the decision core. Reset (synchronous, active low)
// clears the valid flags of both stages and the reassembly state, and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module fragment_reassembly_control (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // header stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // seq_num[15:0], frame_ident[47:16], frag_num[63:48], pay_bytes[79:64]
    input  logic [frc_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // is_padding[0], is_start[1], key_flag[2]
    input  logic [frc_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    // is_end
    input  logic                              i_s_axis_tlast,
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // append_bytes[10:0], seq_gap[11], drop_causes[15:12],
    // done_frame_id[47:16], done_keyframe[48], done_length[72:49], zero[79:73]
    output logic [frc_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // action[1:0], was_padding[2]
    output logic [frc_pkg::OUT_USER_W-1:0]    o_m_axis_tuser,
    // register write port
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [frc_pkg::BYTES_W-1:0]       i_cfg_wdata
);
    import frc_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;
    t_result core_res;
    logic    out_free;
    logic    advance;

    // registers: out-of-range indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keyframe_after_loss <= 1'b1;
            r_cfg.max_frame_size      <= BYTES_W'(4194304);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_AFTER_LOSS: r_cfg.keyframe_after_loss <= i_cfg_wdata[0];
                REG_MAX_FRAME:      r_cfg.max_frame_size      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Result register frees when empty or taken; the input stage advances into
    // it, and the input register refills in the same cycle.
    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign advance         = r_in_vld && out_free;
    assign o_s_axis_tready = !r_in_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    // hold the item payload; no reset needed
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.seq_num     <= i_s_axis_tdata[15:0];
            r_in.frame_ident <= i_s_axis_tdata[47:16];
            r_in.frag_num    <= i_s_axis_tdata[63:48];
            r_in.pay_bytes   <= i_s_axis_tdata[79:64];
            r_in.is_padding  <= i_s_axis_tuser[0];
            r_in.is_start    <= i_s_axis_tuser[1];
            r_in.key_flag    <= i_s_axis_tuser[2];
            r_in.is_end      <= i_s_axis_tlast;
        end
    end

    // decide the held item; state advances only when it moves on
    frc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {7'd0, r_out.done_length, r_out.done_keyframe,
                              r_out.done_frame_id, r_out.drop_causes,
                              r_out.seq_gap, r_out.append_bytes};
    assign o_m_axis_tuser  = {r_out.was_padding, r_out.action};

    // a completed frame never carries a fragment or overflow drop
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out.action == ACT_DONE) |->
        (!r_out.drop_causes[CAUSE_FRAG_ERR] && !r_out.drop_causes[CAUSE_OVERFLOW]))
        else $error("completed frame reports a fragment or overflow drop");

    // padding results carry nothing but the padding mark
    a_pad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out.was_padding) |->
        (r_out.action == ACT_DISCARD && r_out.drop_causes == 4'd0 && !r_out.seq_gap))
        else $error("padding result carries decision fields");

    // a sequence-gap drop implies the gap flag
    a_gap_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out.drop_causes[CAUSE_SEQ_GAP]) |-> r_out.seq_gap)
        else $error("sequence drop without gap flag");

    // completed length never exceeds the frame limit
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && core_res.action == ACT_DONE) |->
        (core_res.done_length <= r_cfg.max_frame_size))
        else $error("completed frame longer than the limit");

endmodule
